// ===== rtl/core/imfe_pkg.sv =====
// Shared types, constants and helpers of the rotor-flux estimator.
package imfe_pkg;

  typedef logic signed [31:0] q_t;

  localparam int QF            = 24;
  localparam int CORDIC_ITERS  = 24;
  localparam int AW            = 27;
  localparam int INTEG_STEP_DEF         = 1678;
  localparam int ROTOR_CURRENT_GAIN_DEF = 16777;

  localparam q_t PI_Q      = 32'sd52707179;
  localparam q_t HALF_PI_Q = 32'sd26353589;
  localparam q_t CORDIC_K  = 32'sd10188013;

  typedef enum logic [2:0] {
    S_IDLE, S_SINCOS, S_CALC, S_AXIS, S_PSI, S_ATAN, S_HOLD
  } state_t;

  typedef enum logic [2:0] {
    REG_POLE   = 3'd0,
    REG_GAIN   = 3'd1,
    REG_R2S    = 3'd2,
    REG_LEAK   = 3'd3,
    REG_RES    = 3'd4,
    REG_S2R    = 3'd5,
    REG_KP     = 3'd6,
    REG_KI     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  function automatic q_t sat_fit(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic q_t sat_add(input q_t a, input q_t b);
    return sat_fit({a[31], a} + {b[31], b});
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    return sat_fit({a[31], a} - {b[31], b});
  endfunction

  function automatic q_t atan_step(input logic [4:0] i);
    unique case (i)
      5'd0: return 32'sd13176795;
      5'd1: return 32'sd7778716;
      5'd2: return 32'sd4110060;
      5'd3: return 32'sd2086331;
      5'd4: return 32'sd1047214;
      5'd5: return 32'sd524117;
      5'd6: return 32'sd262123;
      5'd7: return 32'sd131069;
      default: return 32'sd1 <<< (5'(QF) - i);
    endcase
  endfunction

endpackage

// ===== rtl/core/imfe_in_if.sv =====
// Sample channel: stator currents and voltages.
interface imfe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] current_alpha;
  logic signed [31:0] current_beta;
  logic signed [31:0] voltage_alpha;
  logic signed [31:0] voltage_beta;
  modport source (output valid, current_alpha, current_beta, voltage_alpha, voltage_beta,
                  input ready);
  modport sink (input valid, current_alpha, current_beta, voltage_alpha, voltage_beta,
                output ready);
endinterface

// ===== rtl/core/imfe_out_if.sv =====
// Result channel: flux angle and rotor flux components.
interface imfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [26:0] flux_angle;
  logic signed [31:0] rotor_flux_alpha;
  logic signed [31:0] rotor_flux_beta;
  modport source (output valid, flux_angle, rotor_flux_alpha, rotor_flux_beta, input ready);
  modport sink (input valid, flux_angle, rotor_flux_alpha, rotor_flux_beta, output ready);
endinterface

// ===== rtl/core/induction_motor_flux_estimator.sv =====
// Top level of the induction-motor rotor-flux estimator.
// Usage:
//   sample (valid/ready) brings one request of stationary-frame stator
//   currents and voltages, Q8.24. result (valid/ready) returns the rotor flux
//   angle (27-bit Q3.24 radians) and the voltage-model rotor flux components.
//   cfg_write/cfg_index/cfg_data write the eight gain registers; write them
//   only while the block is idle.
// Flow:
//   A request passes through the sine/cosine CORDIC, then 33 sequencer steps
//   on the shared multiplier (13 common, 7 per axis, 6 for the rotor flux),
//   then the atan2 CORDIC, which ends early when the residual reaches zero,
//   and last the load of the output register. sample.ready is high only in
//   the idle state, so a new request is taken only once the last one is
//   through, also while results drain. The CORDIC iterations and the single
//   multiplier set how long a request takes.
// Reset:
//   rst clears the control and gain registers, filter state and the angle,
//   and drops result.valid.
// Stall:
//   A finished result waits in the output register; the next request is
//   taken meanwhile and its result holds until the register frees.
module induction_motor_flux_estimator
  import imfe_pkg::*;
#(
  parameter int INTEG_STEP         = INTEG_STEP_DEF,
  parameter int ROTOR_CURRENT_GAIN = ROTOR_CURRENT_GAIN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  imfe_in_if.sink     sample,
  imfe_out_if.source  result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam q_t K6 = q_t'(INTEG_STEP);
  localparam q_t K8 = q_t'(ROTOR_CURRENT_GAIN);

  state_t state, state_next;
  logic [3:0] step;
  logic       axis;

  // gain registers
  q_t k1, k2, k3, k4, k5, k7, kp, ki;
  // filter and integrator state
  q_t angle_reg, cmf, pid, piq, bed, beq, sfd, sfq;
  // working registers of one request
  q_t ia, ib, va, vb, sn, cs, kpki, t0, fra, frb, fsa, fsb, e, u, emf, psa, psb;

  logic ovalid;
  logic signed [26:0] fa_o;
  q_t psa_o, psb_o;

  q_t mul_a, mul_b, prod;
  cordic_ctl_t cctl;
  logic cdone;
  q_t c_sin, c_cos, c_ang;

  logic accept;
  q_t sf_cur, fs_cur, pi_cur, be_cur, v_cur, i_cur;
  logic signed [32:0] tsum33;
  q_t tsum;

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == S_IDLE);

  assign sf_cur = axis ? sfq : sfd;
  assign fs_cur = axis ? fsb : fsa;
  assign pi_cur = axis ? piq : pid;
  assign be_cur = axis ? beq : bed;
  assign v_cur  = axis ? vb  : va;
  assign i_cur  = axis ? ib  : ia;

  // exact trapezoid average, floor
  assign tsum33 = {emf[31], emf} + {be_cur[31], be_cur};
  assign tsum   = tsum33[32:1];

  imfe_qmul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  imfe_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cctl),
    .ang     (angle_reg),
    .vx      (psa),
    .vy      (psb),
    .done    (cdone),
    .sin_o   (c_sin),
    .cos_o   (c_cos),
    .angle_o (c_ang)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SINCOS;
      S_SINCOS: if (cdone) state_next = S_CALC;
      S_CALC:   if (step == 4'd12) state_next = S_AXIS;
      S_AXIS:   if (step == 4'd6 && axis) state_next = S_PSI;
      S_PSI:    if (step == 4'd5) state_next = S_ATAN;
      S_ATAN:   if (cdone) state_next = S_HOLD;
      S_HOLD:   if (!ovalid || result.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and CORDIC launch
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    cctl  = '0;
    unique case (state)
      S_IDLE: begin
        cctl.start = accept;
      end
      S_CALC: begin
        unique case (step)
          4'd0:  begin mul_a = ib; mul_b = sn; end
          4'd1:  begin mul_a = ia; mul_b = cs; end
          4'd2:  begin mul_a = kp; mul_b = ki; end
          4'd3:  begin mul_a = k2; mul_b = t0; end
          4'd4:  begin mul_a = k1; mul_b = cmf; end
          4'd6:  begin mul_a = cmf; mul_b = cs; end
          4'd7:  begin mul_a = cmf; mul_b = sn; end
          4'd8:  begin mul_a = k3; mul_b = fra; end
          4'd9:  begin mul_a = k4; mul_b = ia; end
          4'd10: begin mul_a = k3; mul_b = frb; end
          4'd11: begin mul_a = k4; mul_b = ib; end
          default: ;
        endcase
      end
      S_AXIS: begin
        unique case (step)
          4'd1:  begin mul_a = kp; mul_b = e; end
          4'd2:  begin mul_a = kpki; mul_b = e; end
          4'd3:  begin mul_a = k5; mul_b = i_cur; end
          4'd5:  begin mul_a = K6; mul_b = tsum; end
          default: ;
        endcase
      end
      S_PSI: begin
        unique case (step)
          4'd0:  begin mul_a = k7; mul_b = sfd; end
          4'd1:  begin mul_a = K8; mul_b = ia; end
          4'd2:  begin mul_a = k7; mul_b = sfq; end
          4'd3:  begin mul_a = K8; mul_b = ib; end
          4'd5:  begin cctl.start = 1'b1; cctl.vec = 1'b1; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
        if (state_next == S_AXIS) axis <= 1'b0;
      end else if (state == S_AXIS && step == 4'd6) begin
        // wrap to the q axis
        step <= '0;
        axis <= 1'b1;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= '0; k2 <= '0; k3 <= '0; k4 <= '0;
      k5 <= '0; k7 <= '0; kp <= '0; ki <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POLE: k1 <= cfg_data;
        REG_GAIN: k2 <= cfg_data;
        REG_R2S:  k3 <= cfg_data;
        REG_LEAK: k4 <= cfg_data;
        REG_RES:  k5 <= cfg_data;
        REG_S2R:  k7 <= cfg_data;
        REG_KP:   kp <= cfg_data;
        REG_KI:   ki <= cfg_data;
        default: ;
      endcase
    end
  end

  // estimator state, updated by the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg <= '0; cmf <= '0; pid <= '0; piq <= '0;
      bed <= '0; beq <= '0; sfd <= '0; sfq <= '0;
    end else begin
      unique case (state)
        S_CALC: begin
          if (step == 4'd5) cmf <= sat_add(prod, t0);
        end
        S_AXIS: begin
          if (step == 4'd3) begin
            if (axis) piq <= sat_add(piq, prod);
            else pid <= sat_add(pid, prod);
          end
          if (step == 4'd5) begin
            if (axis) beq <= emf;
            else bed <= emf;
          end
          if (step == 4'd6) begin
            if (axis) sfq <= sat_add(sfq, prod);
            else sfd <= sat_add(sfd, prod);
          end
        end
        S_ATAN: begin
          if (cdone) angle_reg <= c_ang;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ia <= sample.current_alpha;
      ib <= sample.current_beta;
      va <= sample.voltage_alpha;
      vb <= sample.voltage_beta;
    end
    unique case (state)
      S_SINCOS: begin
        if (cdone) begin
          sn <= c_sin;
          cs <= c_cos;
        end
      end
      S_CALC: begin
        unique case (step)
          4'd1:  t0   <= prod;
          4'd2:  t0   <= sat_add(t0, prod);
          4'd3:  kpki <= prod;
          4'd4:  t0   <= prod;
          4'd7:  fra  <= prod;
          4'd8:  frb  <= prod;
          4'd9:  t0   <= prod;
          4'd10: fsa  <= sat_add(t0, prod);
          4'd11: t0   <= prod;
          4'd12: fsb  <= sat_add(t0, prod);
          default: ;
        endcase
      end
      S_AXIS: begin
        unique case (step)
          4'd0: e   <= sat_sub(sf_cur, fs_cur);
          4'd2: u   <= sat_add(prod, pi_cur);
          4'd3: emf <= sat_sub(v_cur, u);
          4'd4: emf <= sat_sub(emf, prod);
          default: ;
        endcase
      end
      S_PSI: begin
        unique case (step)
          4'd1: t0  <= prod;
          4'd2: psa <= sat_sub(t0, prod);
          4'd3: t0  <= prod;
          4'd4: psb <= sat_sub(t0, prod);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_HOLD && (!ovalid || result.ready)) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && (!ovalid || result.ready)) begin
      fa_o  <= angle_reg[AW-1:0];
      psa_o <= psa;
      psb_o <= psb;
    end
  end

  assign result.valid            = ovalid;
  assign result.flux_angle       = fa_o;
  assign result.rotor_flux_alpha = psa_o;
  assign result.rotor_flux_beta  = psb_o;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SINCOS))
    else $error("accepted request did not start sine/cosine");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (state == S_SINCOS || state == S_ATAN))
    else $error("CORDIC finished outside a waiting state");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (angle_reg <= PI_Q) && (angle_reg >= -PI_Q))
    else $error("flux angle out of range");
`endif

endmodule

// ===== rtl/core/imfe_qmul.sv =====
// Shared Q8.24 multiplier with registered product and saturating rescale.
module imfe_qmul
  import imfe_pkg::*;
(
  input  logic clk,
  input  q_t   a,
  input  q_t   b,
  output q_t   p
);

  logic signed [63:0] prod;
  logic signed [63:0] shifted;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // floor division by 2^24, then clamp to 32 bits
  assign shifted = prod >>> QF;

  always_comb begin
    if (shifted > 64'sd2147483647) p = 32'sh7FFFFFFF;
    else if (shifted < -64'sd2147483648) p = 32'sh80000000;
    else p = shifted[31:0];
  end

endmodule

// ===== rtl/core/imfe_cordic.sv =====
// Iterative CORDIC: rotation for sine/cosine, vectoring for atan2.
module imfe_cordic
  import imfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cordic_ctl_t ctl,
  input  q_t          ang,
  input  q_t          vx,
  input  q_t          vy,
  output logic        done,
  output q_t          sin_o,
  output q_t          cos_o,
  output q_t          angle_o
);

  localparam int XW = 36;

  logic                 busy;
  logic                 vec;
  logic                 neg;
  logic [4:0]           i;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  q_t                   z;
  q_t                   at;

  assign at   = atan_step(i);
  assign done = busy && ((i == 5'(CORDIC_ITERS)) || (vec && (y == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      i <= '0;
      if (ctl.vec) begin
        vec <= 1'b1;
        neg <= 1'b0;
        if (vx < 0) begin
          z <= (vy >= 0) ? PI_Q : -PI_Q;
          x <= -XW'(vx);
          y <= -XW'(vy);
        end else begin
          z <= '0;
          x <= XW'(vx);
          y <= XW'(vy);
        end
      end else begin
        vec <= 1'b0;
        x   <= XW'(CORDIC_K);
        y   <= '0;
        if (ang > HALF_PI_Q) begin
          z   <= ang - PI_Q;
          neg <= 1'b1;
        end else if (ang < -HALF_PI_Q) begin
          z   <= ang + PI_Q;
          neg <= 1'b1;
        end else begin
          z   <= ang;
          neg <= 1'b0;
        end
      end
    end else if (busy && !done) begin
      i <= i + 5'd1;
      if (vec ? (y > 0) : (z < 0)) begin
        x <= x + (y >>> i);
        y <= y - (x >>> i);
        z <= vec ? z + at : z + at;
      end else begin
        x <= x - (y >>> i);
        y <= y + (x >>> i);
        z <= z - at;
      end
    end
  end

  assign cos_o = neg ? -x[31:0] : x[31:0];
  assign sin_o = neg ? -y[31:0] : y[31:0];

  always_comb begin
    if (z > PI_Q) angle_o = PI_Q;
    else if (z < -PI_Q) angle_o = -PI_Q;
    else angle_o = z;
  end

endmodule

// ===== tb/imfe_tb_pkg.sv =====
// Fixed-point arithmetic and the CORDIC models used by the checker.
package imfe_tb_pkg;
  import imfe_pkg::*;

  localparam longint TB_PI   = 52707179;
  localparam longint TB_HPI  = 26353589;
  localparam longint TB_KCOR = 10188013;

  typedef struct packed {
    logic signed [26:0] angle;
    logic signed [31:0] psi_a;
    logic signed [31:0] psi_b;
  } flux_res_t;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic q_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return q_t'(v);
  endfunction

  function automatic q_t fmul(q_t a, q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 24);
  endfunction

  function automatic q_t fadd(q_t a, q_t b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic q_t fsub(q_t a, q_t b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic longint arc_step(int i);
    longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
    if (i < 8) return t[i];
    return 64'sd1 <<< (24 - i);
  endfunction

  function automatic void rotate_sc(q_t ang, output q_t sn, output q_t cs);
    longint z, x, y, nx;
    bit flip;
    z = ang; x = TB_KCOR; y = 0; flip = 0;
    if (z > TB_HPI) begin
      z -= TB_PI; flip = 1;
    end else if (z < -TB_HPI) begin
      z += TB_PI; flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    sn = clamp32(y);
    cs = clamp32(x);
  endfunction

  function automatic q_t vector_angle(q_t yin, q_t xin);
    longint x, y, z, nx;
    x = xin; y = yin; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? TB_PI : -TB_PI;
      x = -x; y = -y;
    end
    for (int i = 0; i < 24; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end
      x = nx;
    end
    if (z > TB_PI) z = TB_PI;
    if (z < -TB_PI) z = -TB_PI;
    return q_t'(z);
  endfunction
endpackage

// ===== tb/imfe_tb_ifs.sv =====
// Configuration write bundle shared by the testbench top and the checker.
interface imfe_cfg_if;
  logic        write;
  logic [2:0]  index;
  logic [31:0] data;
endinterface

// ===== tb/imfe_flux_checker.sv =====
// Flux estimator checker: predicts each result and compares it with the block.
module imfe_flux_checker
  import imfe_pkg::*;
  import imfe_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  imfe_in_if   sample,
  imfe_out_if  result,
  imfe_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);
  q_t gains[8];
  q_t ang_st, cm_flux, pint_d, pint_q, emf_d, emf_q, sflux_d, sflux_q;
  flux_res_t flux_due[$];

  function automatic void axis_update(q_t vin, q_t iin, q_t fs, ref q_t sflux, ref q_t pint,
                                      ref q_t emf_old);
    q_t err, uc, kk, emf;
    longint ts;
    kk = fmul(gains[REG_KP], gains[REG_KI]);
    err = fsub(sflux, fs);
    uc = fadd(fmul(gains[REG_KP], err), pint);
    pint = fadd(pint, fmul(kk, err));
    emf = fsub(fsub(vin, uc), fmul(gains[REG_RES], iin));
    ts = (longint'(emf) + longint'(emf_old)) >>> 1;
    emf_old = emf;
    sflux = fadd(sflux, fmul(q_t'(INTEG_STEP_DEF), q_t'(ts)));
  endfunction

  function automatic flux_res_t estimate_flux(q_t ia, q_t ib, q_t va, q_t vb);
    q_t sn, cs, id_e, fr_a, fr_b, fs_a, fs_b, pa, pb;
    flux_res_t r;
    rotate_sc(ang_st, sn, cs);
    id_e = fadd(fmul(ib, sn), fmul(ia, cs));
    cm_flux = fadd(fmul(gains[REG_POLE], cm_flux), fmul(gains[REG_GAIN], id_e));
    fr_a = fmul(cm_flux, cs);
    fr_b = fmul(cm_flux, sn);
    fs_a = fadd(fmul(gains[REG_R2S], fr_a), fmul(gains[REG_LEAK], ia));
    fs_b = fadd(fmul(gains[REG_R2S], fr_b), fmul(gains[REG_LEAK], ib));
    axis_update(va, ia, fs_a, sflux_d, pint_d, emf_d);
    axis_update(vb, ib, fs_b, sflux_q, pint_q, emf_q);
    pa = fsub(fmul(gains[REG_S2R], sflux_d), fmul(q_t'(ROTOR_CURRENT_GAIN_DEF), ia));
    pb = fsub(fmul(gains[REG_S2R], sflux_q), fmul(q_t'(ROTOR_CURRENT_GAIN_DEF), ib));
    ang_st = vector_angle(pb, pa);
    r.angle = ang_st[26:0];
    r.psi_a = pa;
    r.psi_b = pb;
    return r;
  endfunction

  assign pending = flux_due.size();

  always @(posedge clk) begin
    flux_res_t e;
    if (rst) begin
      foreach (gains[i]) gains[i] = '0;
      {ang_st, cm_flux, pint_d, pint_q, emf_d, emf_q, sflux_d, sflux_q} = '0;
      flux_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg.write) gains[cfg.index] = cfg.data;
      if (sample.valid && sample.ready)
        flux_due.push_back(estimate_flux(sample.current_alpha, sample.current_beta,
                                         sample.voltage_alpha, sample.voltage_beta));
      if (result.valid && result.ready) begin
        if (flux_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          e = flux_due.pop_front();
          if (e.angle !== result.flux_angle || e.psi_a !== result.rotor_flux_alpha ||
              e.psi_b !== result.rotor_flux_beta) begin
            if (fail_count < 10)
              $display("mismatch: exp ang %0d a %0d b %0d, got ang %0d a %0d b %0d",
                       e.angle, e.psi_a, e.psi_b, result.flux_angle,
                       result.rotor_flux_alpha, result.rotor_flux_beta);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/induction_motor_flux_estimator_tb.sv =====
// Testbench top: stimulus, idling, configuration phases and verdict.
module induction_motor_flux_estimator_tb;
  import imfe_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending;

  imfe_in_if  sample();
  imfe_out_if result();
  imfe_cfg_if cfg();

  induction_motor_flux_estimator u_dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_write(cfg.write), .cfg_index(cfg.index), .cfg_data(cfg.data)
  );

  imfe_flux_checker u_chk (
    .clk(clk), .rst(rst), .sample(sample), .result(result), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; zero often so back-to-back runs occur.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Random receiver stalls, now and then a long one.
  initial begin
    result.ready = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) result.ready <= ~result.ready;
      else if ($urandom_range(0, 199) == 0) begin
        result.ready <= 0;
        repeat ($urandom_range(50, 300)) @(posedge clk);
        result.ready <= 1;
      end
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 6))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
    endcase
  endfunction

  // Small gains keep the loop near sensible operation; extremes are mixed in.
  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
    endcase
  endfunction

  // Drop the enable for one cycle after each write so writes never share a step.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg.write <= 1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    cfg.write <= 0;
    @(posedge clk);
  endtask

  // Hold off until every request has its result, then let the block settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_request(logic [31:0] ia, ib, va, vb);
    sample.valid <= 1;
    sample.current_alpha <= ia;
    sample.current_beta  <= ib;
    sample.voltage_alpha <= va;
    sample.voltage_beta  <= vb;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    // Drop valid only when a gap follows, so valid is never lowered and raised in one step.
    begin
      int g;
      g = gap_len();
      if (g > 0) begin
        sample.valid <= 0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic set_all(logic [31:0] v);
    for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), v);
  endtask

  initial begin
    logic [31:0] ex[4];
    sample.valid = 0;
    sample.current_alpha = 0; sample.current_beta = 0;
    sample.voltage_alpha = 0; sample.voltage_beta = 0;
    cfg.write = 0; cfg.index = REG_POLE; cfg.data = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero vector with reset gains, then field extremes.
    ex = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    send_request(0, 0, 0, 0);
    for (int k = 0; k < 4; k++)
      send_request(ex[k], ex[(k + 1) % 4], ex[(k + 2) % 4], ex[(k + 3) % 4]);
    sample.valid <= 0;
    drain();

    // Extreme gains: saturate every integrator, then the negative extreme.
    set_all(32'h7FFFFFFF);
    for (int k = 0; k < 6; k++)
      send_request(ex[k % 4], ex[(k + 3) % 4], ex[(k + 1) % 4], ex[(k + 2) % 4]);
    sample.valid <= 0;
    drain();
    set_all(32'h80000000);
    for (int k = 0; k < 6; k++)
      send_request(ex[(k + 2) % 4], ex[k % 4], ex[(k + 3) % 4], ex[(k + 1) % 4]);
    sample.valid <= 0;
    drain();

    // Moderate gains: unity rotor factors give real angles in every quadrant.
    write_reg(REG_POLE, 32'h00F00000);
    write_reg(REG_GAIN, 32'h00100000);
    write_reg(REG_R2S, 32'h01000000);
    write_reg(REG_LEAK, 32'h00080000);
    write_reg(REG_RES, 32'h00040000);
    write_reg(REG_S2R, 32'h01000000);
    write_reg(REG_KP, 32'h00200000);
    write_reg(REG_KI, 32'h00100000);
    for (int k = 0; k < 8; k++)
      send_request((k & 1) ? 32'hFF000000 : 32'h01000000, (k & 2) ? 32'hFF000000 : 32'h01000000,
                   $urandom, $urandom);
    sample.valid <= 0;
    drain();

    // Random phases; two in three get fresh gains, the rest keep the gains before them.
    for (int ph = 0; ph < 15; ph++) begin
      if (ph % 3 != 0)
        for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), rand_gain());
      for (int k = 0; k < 100; k++)
        send_request(rand_field(), rand_field(), rand_field(), rand_field());
      sample.valid <= 0;
      drain();
    end

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #100000000;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/imfe_pkg.sv
rtl/core/imfe_in_if.sv
rtl/core/imfe_out_if.sv
rtl/core/imfe_qmul.sv
rtl/core/imfe_cordic.sv
rtl/core/induction_motor_flux_estimator.sv
tb/imfe_tb_pkg.sv
tb/imfe_tb_ifs.sv
tb/imfe_flux_checker.sv
tb/induction_motor_flux_estimator_tb.sv
